>>> sv/interval_coverage_set_unit_macros.svh
// Assertion helpers for the interval coverage set unit
`ifndef INTERVAL_COVERAGE_SET_UNIT_MACROS_SVH
`define INTERVAL_COVERAGE_SET_UNIT_MACROS_SVH

// Sampling event shared by all checks
`define ICS_CLK @(posedge clock)

// Clocked assertion, quiet during reset
`define ICS_ASSERT(label, prop, msg) \
   label: assert property (`ICS_CLK disable iff (reset) prop) else $error(msg);

`endif

>>> sv/ics_pkg.sv
`timescale 1ns / 1ps
package ics_pkg;

   localparam int DW = 64;

   // item modes
   localparam logic [2:0] MODE_ADD     = 3'd0;
   localparam logic [2:0] MODE_REMOVE  = 3'd1;
   localparam logic [2:0] MODE_COVERED = 3'd2;
   localparam logic [2:0] MODE_OVERLAP = 3'd3;
   localparam logic [2:0] MODE_HOLES   = 3'd4;

   // cell operations
   localparam logic [1:0] OP_HOLD = 2'd0;
   localparam logic [1:0] OP_LOAD = 2'd1;
   localparam logic [1:0] OP_PREV = 2'd2;
   localparam logic [1:0] OP_NEXT = 2'd3;

   typedef struct packed {
      logic [1:0]    op;
      logic [DW-1:0] start;
      logic [DW-1:0] len;
   } cell_ctl_type;

   // true when range [s,e) overlaps stored range [rs,re)
   function automatic logic ics_hit(input logic [DW-1:0] s, input logic [DW-1:0] e,
                                    input logic [DW-1:0] rs, input logic [DW-1:0] re);
      ics_hit = (s >= rs && s < re) || (e > rs && e <= re) || (s < rs && e > re);
   endfunction

endpackage

>>> sv/ics_cell.sv
`timescale 1ns / 1ps
module ics_cell (
   input  logic                 clock,
   input  ics_pkg::cell_ctl_type ctl,
   input  logic [63:0]          prev_start,
   input  logic [63:0]          prev_len,
   input  logic [63:0]          next_start,
   input  logic [63:0]          next_len,
   output logic [63:0]          start,
   output logic [63:0]          len
);
   import ics_pkg::*;

   logic [DW-1:0] start_ff, start_in;
   logic [DW-1:0] len_ff, len_in;

   // pick the new contents: hold, load, or take a neighbor
   always_comb begin
      start_in = start_ff;
      len_in   = len_ff;
      case (ctl.op)
         OP_LOAD: begin
            start_in = ctl.start;
            len_in   = ctl.len;
         end
         OP_PREV: begin
            start_in = prev_start;
            len_in   = prev_len;
         end
         OP_NEXT: begin
            start_in = next_start;
            len_in   = next_len;
         end
         default: begin
            start_in = start_ff;
            len_in   = len_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      start_ff <= start_in;
      len_ff   <= len_in;
   end

   assign start = start_ff;
   assign len   = len_ff;
endmodule

>>> sv/interval_coverage_set_unit.sv
`timescale 1ns / 1ps
// Interval coverage set unit: a sorted table of up to CAPACITY disjoint
// address ranges held in a row of cells.
// Input channel req_: tuser carries the mode (add, remove, is covered,
// is overlap, find holes), tdata the start address and the length.
// Result channel rsp_: one transfer per result, tlast on the final one.
// A new item is taken only once the previous one has run to its end.
// Steps per item:
//   lookup: a binary search, one probe a cycle
//   add/remove: lookup, then a walk over the stored ranges reached, then
//   the emptied entries closed up (the row shifts one place a cycle); a remove
//   that splits a range runs a second lookup and add for the tail piece
//   queries: lookup, then a check of the range found and the one before it
//   find holes: one result a cycle while the receiver takes them
// The row is read through one read port, one cell read a cycle.
// Reset empties the table at once (count cleared); no clearing pass.
// Results sit in an output register; while the receiver stalls, the
// sequencer waits at its next result and holds the table as it is.
module interval_coverage_set_unit #(
   parameter int CAPACITY = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [127:0] req_tdata,   // start_req[63:0], length[127:64]
   input  logic [2:0]   req_tuser,   // mode[2:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,   // answer[0], hole_start[64:1],
                                     // hole_length[128:65], overflow[129], zero pad
   output logic [0:0]   rsp_tuser,   // has_range[0]
   output logic         rsp_tlast
);
   import ics_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
   localparam logic [CW-1:0] ONE_C = CW'(1);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_LOC  = 5'd1;
   localparam logic [4:0] S_A0   = 5'd2;
   localparam logic [4:0] S_A1   = 5'd3;
   localparam logic [4:0] S_INS  = 5'd4;
   localparam logic [4:0] S_DN   = 5'd5;
   localparam logic [4:0] S_R0   = 5'd6;
   localparam logic [4:0] S_R1   = 5'd7;
   localparam logic [4:0] S_CV0  = 5'd8;
   localparam logic [4:0] S_CV1  = 5'd9;
   localparam logic [4:0] S_OV0  = 5'd10;
   localparam logic [4:0] S_OV1  = 5'd11;
   localparam logic [4:0] S_H0   = 5'd12;
   localparam logic [4:0] S_H1   = 5'd13;
   localparam logic [4:0] S_H2   = 5'd14;
   localparam logic [4:0] S_H3   = 5'd15;
   localparam logic [4:0] S_EMIT = 5'd16;

   logic [4:0]    st_ff, st_in;
   logic [2:0]    mode_ff, mode_in;
   logic [DW-1:0] s_ff, s_in, l_ff, l_in, e_ff, e_in;
   logic [CW-1:0] cnt_ff, cnt_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [CW-1:0] r_ff, r_in, p_ff, p_in, ci_ff, ci_in;
   logic [CW-1:0] ee_ff, ee_in, eb_ff, eb_in, base_ff, base_in, n_ff, n_in;
   logic          civ_ff, civ_in, ins_ff, ins_in, tail_ff, tail_in;
   logic [DW-1:0] cur_s_ff, cur_s_in, cur_l_ff, cur_l_in, cur_e_ff, cur_e_in;
   logic [DW-1:0] pe_ff, pe_in, el_ff, el_in;
   logic          res_ans_ff, res_ans_in, res_has_ff, res_has_in, res_ovf_ff, res_ovf_in;
   logic [DW-1:0] res_hs_ff, res_hs_in, res_hl_ff, res_hl_in;
   logic          ov_ff, ov_in, o_ans_ff, o_ans_in, o_has_ff, o_has_in;
   logic          o_last_ff, o_last_in, o_ovf_ff, o_ovf_in;
   logic [DW-1:0] o_hs_ff, o_hs_in, o_hl_ff, o_hl_in;

   // cell row
   logic [DW-1:0] c_start [CAPACITY];
   logic [DW-1:0] c_len   [CAPACITY];
   cell_ctl_type  c_ctl   [CAPACITY];

   logic          wr_en, up_en, dn_en;
   logic [CW-1:0] wr_idx;
   logic [DW-1:0] wr_s, wr_l;
   logic [CW-1:0] rd_idx, mid;
   logic [DW-1:0] rs, rl, re, sl;
   logic          can_emit, emit;
   logic          e_ans, e_has, e_last, e_ovf;
   logic [DW-1:0] e_hs, e_hl;
   logic [DW-1:0] new_l;

   assign can_emit = !ov_ff || rsp_tready;
   assign mid      = CW'(({1'b0, lo_ff} + {1'b0, hi_ff}) >> 1);
   assign sl       = s_ff + l_ff;

   genvar gi;
   generate
      for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
         logic [DW-1:0] ps, pl, nxs, nxl;
         if (gi == 0) begin : g_first
            assign ps = '0;
            assign pl = '0;
         end else begin : g_mid
            assign ps = c_start[gi-1];
            assign pl = c_len[gi-1];
         end
         if (gi == CAPACITY - 1) begin : g_last
            assign nxs = '0;
            assign nxl = '0;
         end else begin : g_tail
            assign nxs = c_start[gi+1];
            assign nxl = c_len[gi+1];
         end

         // decode this cell's operation from the row command
         always_comb begin
            c_ctl[gi].start = wr_s;
            c_ctl[gi].len   = wr_l;
            if (up_en && base_ff == CW'(gi))
               c_ctl[gi].op = OP_LOAD;
            else if (up_en && base_ff < CW'(gi))
               c_ctl[gi].op = OP_PREV;
            else if (dn_en && base_ff <= CW'(gi))
               c_ctl[gi].op = OP_NEXT;
            else if (wr_en && wr_idx == CW'(gi))
               c_ctl[gi].op = OP_LOAD;
            else
               c_ctl[gi].op = OP_HOLD;
         end

         ics_cell u_cell (
            .clock      (clock),
            .ctl        (c_ctl[gi]),
            .prev_start (ps),
            .prev_len   (pl),
            .next_start (nxs),
            .next_len   (nxl),
            .start      (c_start[gi]),
            .len        (c_len[gi])
         );
      end
   endgenerate

   // read port: one cell per cycle
   always_comb begin
      unique case (st_ff)
         S_LOC:          rd_idx = mid;
         S_A0, S_R0:     rd_idx = r_ff - ONE_C;
         S_A1, S_H2:     rd_idx = p_ff;
         S_R1, S_CV0:    rd_idx = r_ff;
         S_OV0:          rd_idx = r_ff;
         S_CV1, S_OV1:   rd_idx = r_ff - ONE_C;
         S_H0:           rd_idx = cnt_ff - ONE_C;
         default:        rd_idx = '0;
      endcase
      rs = '0;
      rl = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (rd_idx == CW'(i)) begin
            rs = c_start[i];
            rl = c_len[i];
         end
      end
      re = rs + rl;
   end

   // sequencer
   always_comb begin
      st_in = st_ff;     mode_in = mode_ff;
      s_in = s_ff;       l_in = l_ff;       e_in = e_ff;
      cnt_in = cnt_ff;   lo_in = lo_ff;     hi_in = hi_ff;
      r_in = r_ff;       p_in = p_ff;       ci_in = ci_ff;
      ee_in = ee_ff;     eb_in = eb_ff;     base_in = base_ff;  n_in = n_ff;
      civ_in = civ_ff;   ins_in = ins_ff;   tail_in = tail_ff;
      cur_s_in = cur_s_ff; cur_l_in = cur_l_ff; cur_e_in = cur_e_ff;
      pe_in = pe_ff;     el_in = el_ff;
      res_ans_in = res_ans_ff; res_has_in = res_has_ff; res_ovf_in = res_ovf_ff;
      res_hs_in = res_hs_ff;   res_hl_in = res_hl_ff;
      wr_en = 1'b0; up_en = 1'b0; dn_en = 1'b0;
      wr_idx = '0;  wr_s = '0;    wr_l = '0;
      emit = 1'b0;
      e_ans = 1'b0; e_has = 1'b0; e_last = 1'b0; e_ovf = 1'b0;
      e_hs = '0;    e_hl = '0;
      new_l = '0;
      req_tready = (st_ff == S_IDLE);

      unique case (st_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in = req_tuser;
               s_in = req_tdata[63:0];
               l_in = req_tdata[127:64];
               e_in = req_tdata[63:0] + req_tdata[127:64];
               lo_in = '0;
               hi_in = cnt_ff;
               res_ans_in = 1'b0; res_has_in = 1'b0; res_ovf_in = 1'b0;
               res_hs_in = '0;    res_hl_in = '0;
               st_in = S_EMIT;
               case (req_tuser)
                  MODE_ADD: begin
                     if (req_tdata[127:64] != '0) begin
                        if (cnt_ff == '0) begin
                           wr_en = 1'b1;
                           wr_s = req_tdata[63:0];
                           wr_l = req_tdata[127:64];
                           cnt_in = ONE_C;
                        end else begin
                           st_in = S_LOC;
                        end
                     end
                  end
                  MODE_REMOVE, MODE_OVERLAP: begin
                     if (cnt_ff != '0 && req_tdata[127:64] != '0)
                        st_in = S_LOC;
                  end
                  MODE_COVERED: begin
                     if (cnt_ff != '0)
                        st_in = S_LOC;
                  end
                  MODE_HOLES: begin
                     if (req_tdata[127:64] != '0) begin
                        if (cnt_ff == '0) begin
                           res_has_in = 1'b1;
                           res_hs_in = req_tdata[63:0];
                           res_hl_in = req_tdata[127:64];
                        end else begin
                           st_in = S_H0;
                        end
                     end
                  end
                  default: st_in = S_EMIT;
               endcase
            end
         end

         // binary search for the first start not below the key
         S_LOC: begin
            if (lo_ff >= hi_ff) begin
               r_in = lo_ff;
               case (mode_ff)
                  MODE_ADD:     st_in = S_A0;
                  MODE_REMOVE:  st_in = S_R0;
                  MODE_COVERED: st_in = S_CV0;
                  default:      st_in = S_OV0;
               endcase
            end else if (rs > s_ff) begin
               hi_in = mid;
            end else if (rs < s_ff) begin
               lo_in = mid + ONE_C;
            end else begin
               r_in = mid;
               case (mode_ff)
                  MODE_ADD:     st_in = S_A0;
                  MODE_REMOVE:  st_in = S_R0;
                  MODE_COVERED: st_in = S_CV0;
                  default:      st_in = S_OV0;
               endcase
            end
         end

         // add: merge into the preceding range if it reaches the new start
         S_A0: begin
            p_in = r_ff;
            st_in = S_A1;
            if (r_ff != '0 && s_ff <= re) begin
               ins_in = 1'b0;
               if (sl > re) begin
                  wr_en = 1'b1;
                  wr_idx = r_ff - ONE_C;
                  wr_s = rs;
                  wr_l = sl - rs;
                  ci_in = r_ff - ONE_C;
                  civ_in = 1'b1;
                  cur_s_in = rs;
                  cur_l_in = sl - rs;
                  cur_e_in = sl;
               end else begin
                  st_in = S_EMIT;
               end
            end else begin
               ins_in = 1'b1;
               civ_in = 1'b0;
               cur_s_in = s_ff;
               cur_l_in = l_ff;
               cur_e_in = sl;
            end
         end

         // add: absorb following ranges that the merged range reaches
         S_A1: begin
            if (p_ff >= cnt_ff || cur_e_ff < rs) begin
               if (p_ff > r_ff) begin
                  base_in = r_ff;
                  n_in = p_ff - r_ff;
                  st_in = S_DN;
               end else if (ins_ff) begin
                  base_in = r_ff;
                  st_in = S_INS;
               end else begin
                  st_in = S_EMIT;
               end
            end else begin
               new_l = cur_l_ff;
               if (re > cur_e_ff) begin
                  new_l = re - cur_s_ff;
                  cur_l_in = new_l;
                  cur_e_in = re;
                  if (civ_ff) begin
                     wr_en = 1'b1;
                     wr_idx = ci_ff;
                     wr_s = cur_s_ff;
                     wr_l = new_l;
                  end else begin
                     l_in = new_l;
                  end
               end
               if (ins_ff) begin
                  wr_en = 1'b1;
                  wr_idx = p_ff;
                  wr_s = s_ff;
                  wr_l = new_l;
                  ins_in = 1'b0;
                  ci_in = p_ff;
                  civ_in = 1'b1;
                  r_in = r_ff + ONE_C;
               end
               p_in = p_ff + ONE_C;
            end
         end

         // add: open a slot at r and load the new range, or flag overflow when full
         S_INS: begin
            if (cnt_ff >= CAP_C) begin
               res_ovf_in = 1'b1;
            end else begin
               up_en = 1'b1;
               wr_s = s_ff;
               wr_l = l_ff;
               cnt_in = cnt_ff + ONE_C;
            end
            st_in = S_EMIT;
         end

         // close up emptied entries one place per cycle
         S_DN: begin
            if (n_ff == '0) begin
               st_in = S_EMIT;
            end else begin
               dn_en = 1'b1;
               cnt_in = cnt_ff - ONE_C;
               n_in = n_ff - ONE_C;
            end
         end

         // remove: cut the preceding range
         S_R0: begin
            ee_in = r_ff;
            eb_in = r_ff;
            st_in = S_R1;
            if (r_ff != '0 && s_ff < re) begin
               res_ans_in = 1'b1;
               wr_en = 1'b1;
               wr_idx = r_ff - ONE_C;
               if (s_ff == rs) begin
                  if (e_ff >= re) begin
                     wr_s = rs;
                     wr_l = '0;
                     eb_in = r_ff - ONE_C;
                  end else begin
                     wr_s = e_ff;
                     wr_l = re - e_ff;
                  end
               end else begin
                  wr_s = rs;
                  wr_l = s_ff - rs;
                  if (e_ff < re) begin
                     // split: put back the tail piece as an add
                     mode_in = MODE_ADD;
                     s_in = e_ff;
                     l_in = re - e_ff;
                     lo_in = '0;
                     hi_in = cnt_ff;
                     st_in = S_LOC;
                  end
               end
            end
         end

         // remove: drop or trim the ranges the cut reaches
         S_R1: begin
            if (r_ff < cnt_ff && rs < e_ff) begin
               res_ans_in = 1'b1;
               if (e_ff >= re) begin
                  ee_in = ee_ff + ONE_C;
                  r_in = r_ff + ONE_C;
               end else begin
                  wr_en = 1'b1;
                  wr_idx = r_ff;
                  wr_s = e_ff;
                  wr_l = re - e_ff;
               end
            end else if (ee_ff > eb_ff) begin
               base_in = eb_ff;
               n_in = ee_ff - eb_ff;
               st_in = S_DN;
            end else begin
               st_in = S_EMIT;
            end
         end

         S_CV0: begin
            st_in = S_EMIT;
            if (r_ff < cnt_ff && s_ff >= rs)
               res_ans_in = (e_ff <= re);
            else if (r_ff != '0)
               st_in = S_CV1;
         end

         S_CV1: begin
            res_ans_in = (e_ff <= re);
            st_in = S_EMIT;
         end

         S_OV0: begin
            st_in = S_EMIT;
            if (r_ff < cnt_ff && ics_hit(s_ff, e_ff, rs, re))
               res_ans_in = 1'b1;
            else if (r_ff != '0)
               st_in = S_OV1;
         end

         S_OV1: begin
            res_ans_in = ics_hit(s_ff, e_ff, rs, re);
            st_in = S_EMIT;
         end

         // holes: look at the last range first to know where results end
         S_H0: begin
            el_in = re;
            tail_in = (e_ff > re);
            st_in = S_H1;
         end

         S_H1: begin
            if (s_ff < rs && !can_emit) begin
               st_in = S_H1;
            end else begin
               if (s_ff < rs) begin
                  emit = 1'b1;
                  e_has = 1'b1;
                  e_hs = s_ff;
                  e_hl = rs - s_ff;
                  e_last = (cnt_ff == ONE_C) && !tail_ff;
               end
               pe_in = re;
               p_in = ONE_C;
               if (cnt_ff > ONE_C)
                  st_in = S_H2;
               else if (tail_ff)
                  st_in = S_H3;
               else if (s_ff < rs)
                  st_in = S_IDLE;
               else
                  st_in = S_EMIT;
            end
         end

         S_H2: begin
            if (can_emit) begin
               emit = 1'b1;
               e_has = 1'b1;
               e_hs = pe_ff;
               e_hl = rs - pe_ff;
               e_last = (p_ff == cnt_ff - ONE_C) && !tail_ff;
               pe_in = re;
               p_in = p_ff + ONE_C;
               if (p_ff == cnt_ff - ONE_C)
                  st_in = tail_ff ? S_H3 : S_IDLE;
            end
         end

         S_H3: begin
            if (can_emit) begin
               emit = 1'b1;
               e_has = 1'b1;
               e_hs = el_ff;
               e_hl = e_ff - el_ff;
               e_last = 1'b1;
               st_in = S_IDLE;
            end
         end

         S_EMIT: begin
            if (can_emit) begin
               emit = 1'b1;
               e_ans = res_ans_ff;
               e_has = res_has_ff;
               e_hs = res_hs_ff;
               e_hl = res_hl_ff;
               e_ovf = res_ovf_ff;
               e_last = 1'b1;
               st_in = S_IDLE;
            end
         end

         default: st_in = S_IDLE;
      endcase
   end

   // output register
   always_comb begin
      ov_in = ov_ff;
      o_ans_in = o_ans_ff; o_has_in = o_has_ff; o_last_in = o_last_ff;
      o_ovf_in = o_ovf_ff; o_hs_in = o_hs_ff;   o_hl_in = o_hl_ff;
      if (emit) begin
         ov_in = 1'b1;
         o_ans_in = e_ans; o_has_in = e_has; o_last_in = e_last;
         o_ovf_in = e_ovf; o_hs_in = e_hs;   o_hl_in = e_hl;
      end else if (rsp_tready) begin
         ov_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= S_IDLE;
         cnt_ff <= '0;
         ov_ff  <= 1'b0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
         ov_ff  <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;  s_ff <= s_in;  l_ff <= l_in;  e_ff <= e_in;
      lo_ff <= lo_in;  hi_ff <= hi_in;  r_ff <= r_in;  p_ff <= p_in;  ci_ff <= ci_in;
      ee_ff <= ee_in;  eb_ff <= eb_in;  base_ff <= base_in;  n_ff <= n_in;
      civ_ff <= civ_in;  ins_ff <= ins_in;  tail_ff <= tail_in;
      cur_s_ff <= cur_s_in;  cur_l_ff <= cur_l_in;  cur_e_ff <= cur_e_in;
      pe_ff <= pe_in;  el_ff <= el_in;
      res_ans_ff <= res_ans_in;  res_has_ff <= res_has_in;  res_ovf_ff <= res_ovf_in;
      res_hs_ff <= res_hs_in;  res_hl_ff <= res_hl_in;
      o_ans_ff <= o_ans_in;  o_has_ff <= o_has_in;  o_last_ff <= o_last_in;
      o_ovf_ff <= o_ovf_in;  o_hs_ff <= o_hs_in;  o_hl_ff <= o_hl_in;
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = {6'd0, o_ovf_ff, o_hl_ff, o_hs_ff, o_ans_ff};
   assign rsp_tuser  = o_has_ff;
   assign rsp_tlast  = o_last_ff;
endmodule

>>> sv/ics_checker.sv
`timescale 1ns / 1ps
`include "interval_coverage_set_unit_macros.svh"
module ics_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [135:0] rsp_tdata,
   input logic [0:0]   rsp_tuser,
   input logic         rsp_tlast
);
   // a stalled result holds
   `ICS_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
   // a hole result carries no answer and no overflow
   `ICS_ASSERT(a_hole_clean, rsp_tvalid && rsp_tuser[0] |-> !rsp_tdata[0] && !rsp_tdata[129], "hole result with flags set")
   // overflow comes only on the final result of an item
   `ICS_ASSERT(a_ovf_last, rsp_tvalid && rsp_tdata[129] |-> rsp_tlast, "overflow not on final result")
   // one item at a time: ready drops after a transfer in
   `ICS_ASSERT(a_one_item, req_tvalid && req_tready |=> !req_tready, "second item taken back to back")
endmodule

bind interval_coverage_set_unit ics_checker u_ics_checker (.*);
